// ----- rtl/md5_message_digest_macros.svh -----
// ----------------------------------------------------------------------------
// MD5 message digest assertion macros
// Shared property macros for the MD5 block; empty when built for synthesis.
// The enclosing module must provide clk and rst.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 property violated");
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 property violated");
`else
`define MD5_ASSERT_SAME(lbl, ante, cons)
`define MD5_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Types, constants and step functions shared by the MD5 block.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] quad_t;

  localparam quad_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] PAD_LIMIT   = 6'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  localparam word_t SINE_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Source of the block words seen by the round unit.
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_MARK_LEN,
    SRC_LEN
  } blk_src_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] round;
    logic [5:0] ahead;
  } rnd_ctl_t;

  function automatic word_t round_f(input logic [5:0] r, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (r[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    case (r[5:4])
      2'd0: g = r4;
      2'd1: g = r4 * 4'd5 + 4'd1;
      2'd2: g = r4 * 4'd3 + 4'd5;
      default: g = r4 * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    return ROT_TABLE[{r[5:4], r[1:0]}];
  endfunction

  function automatic word_t rotl32(input word_t v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic word_t swap32(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic blk_src_t pad_select(input logic [5:0] fill);
    return (fill >= PAD_LIMIT) ? SRC_MARK : SRC_MARK_LEN;
  endfunction

endpackage

// ----- rtl/md5_msg_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message block buffer
// Holds sixteen little-endian block words filled one byte at a time and
// presents one word per cycle, with the padding pattern overlaid on demand.
// ----------------------------------------------------------------------------
module md5_msg_buf (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [5:0]        wr_pos,
  input  logic [7:0]        wr_byte,
  input  logic [3:0]        rd_idx,
  input  md5_pkg::blk_src_t src,
  input  logic [5:0]        fill,
  input  logic [63:0]       bit_len,
  output md5_pkg::word_t    rd_word
);

  md5_pkg::word_t words [16];
  md5_pkg::word_t raw;
  logic [5:0]     pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_comb begin
    raw     = words[rd_idx];
    rd_word = raw;
    pos     = '0;
    for (int j = 0; j < 4; j++) begin
      pos = {rd_idx, 2'(j)};
      case (src)
        md5_pkg::SRC_MSG: rd_word[8*j +: 8] = raw[8*j +: 8];
        md5_pkg::SRC_MARK, md5_pkg::SRC_MARK_LEN: begin
          if (pos < fill) begin
            rd_word[8*j +: 8] = raw[8*j +: 8];
          end else if (pos == fill) begin
            rd_word[8*j +: 8] = md5_pkg::PAD_BYTE;
          end else begin
            rd_word[8*j +: 8] = 8'h00;
          end
        end
        default: rd_word[8*j +: 8] = 8'h00;
      endcase
    end
    if (src == md5_pkg::SRC_MARK_LEN || src == md5_pkg::SRC_LEN) begin
      if (rd_idx == md5_pkg::LEN_LO_WORD) begin
        rd_word = bit_len[31:0];
      end else if (rd_idx == md5_pkg::LEN_HI_WORD) begin
        rd_word = bit_len[63:32];
      end
    end
  end

endmodule

// ----- rtl/md5_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round unit
// Working registers A to D and one shared MD5 step, applied once per cycle while ctl.step is set.
// The constant and message word of the following step are pre-added.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic              clk,
  input  md5_pkg::rnd_ctl_t ctl,
  input  md5_pkg::quad_t    chain,
  input  md5_pkg::word_t    m_word,
  output md5_pkg::quad_t    work
);

  md5_pkg::word_t pre;
  md5_pkg::word_t f;
  md5_pkg::word_t sum;
  md5_pkg::word_t b_next;

  always_comb begin
    f      = md5_pkg::round_f(ctl.round, work[1], work[2], work[3]);
    sum    = pre + f;
    b_next = work[1] + md5_pkg::rotl32(sum, md5_pkg::rot_amount(ctl.round));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= chain;
      pre  <= chain[0] + md5_pkg::SINE_TABLE[ctl.ahead] + m_word;
    end else if (ctl.step) begin
      work[0] <= work[3];
      work[1] <= b_next;
      work[2] <= work[1];
      work[3] <= work[2];
      pre     <= work[3] + md5_pkg::SINE_TABLE[ctl.ahead] + m_word;
    end
  end

endmodule

// ----- rtl/md5_message_digest.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-wide MD5 hasher with padding and a 128-bit digest output register.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  message   in         msg_valid / msg_stall        data_byte, has_byte, last
//  digest    out        digest_valid / digest_stall  digest_high, digest_low
//
// A byte that does not close a block is written to the buffer and the block stays idle.
// A byte that closes a block starts a block pass: load, then 64 steps of the single round
// unit, then the chaining add.
// An item with last also runs the padding, which needs one or two more block passes.
// Reset is synchronous; the block is ready in the first cycle after it.
// A stalled digest holds in its register while the next message is taken, and
// the digest of that message waits until the held transfer completes.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  input  logic        msg_valid,
  output logic        msg_stall,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low,
  output logic        digest_valid,
  input  logic        digest_stall
);

`include "md5_message_digest_macros.svh"

  md5_pkg::state_t   state, state_next;
  md5_pkg::blk_src_t src, src_next;
  md5_pkg::quad_t    chain, chain_next;
  md5_pkg::quad_t    work;
  md5_pkg::word_t    m_word;
  md5_pkg::rnd_ctl_t ctl;
  logic [60:0]       count, count_next;
  logic [5:0]        round, round_next;
  logic              fin, fin_next;
  logic              digest_valid_next;
  logic              load_digest;
  logic              wr_en;
  logic              accept;
  logic [5:0]        pos;

  assign msg_stall = (state != md5_pkg::ST_IDLE);
  assign accept    = msg_valid && !msg_stall;
  assign pos       = count[5:0];

  md5_msg_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_pos  (pos),
    .wr_byte (data_byte),
    .rd_idx  (md5_pkg::msg_index(ctl.ahead)),
    .src     (src),
    .fill    (pos),
    .bit_len ({count, 3'b000}),
    .rd_word (m_word)
  );

  md5_round u_round (
    .clk    (clk),
    .ctl    (ctl),
    .chain  (chain),
    .m_word (m_word),
    .work   (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src          <= md5_pkg::SRC_MSG;
      chain        <= md5_pkg::CHAIN_INIT;
      count        <= '0;
      round        <= '0;
      fin          <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      src          <= src_next;
      chain        <= chain_next;
      count        <= count_next;
      round        <= round_next;
      fin          <= fin_next;
      digest_valid <= digest_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_digest) begin
      digest_high <= {md5_pkg::swap32(chain[0]), md5_pkg::swap32(chain[1])};
      digest_low  <= {md5_pkg::swap32(chain[2]), md5_pkg::swap32(chain[3])};
    end
  end

  always_comb begin
    state_next        = state;
    src_next          = src;
    chain_next        = chain;
    count_next        = count;
    round_next        = round;
    fin_next          = fin;
    digest_valid_next = digest_valid && digest_stall;
    load_digest       = 1'b0;
    wr_en             = 1'b0;
    ctl.load          = 1'b0;
    ctl.step          = 1'b0;
    ctl.round         = round;
    ctl.ahead         = round + 6'd1;

    case (state)
      md5_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_byte) begin
            wr_en      = 1'b1;
            count_next = count + 61'd1;
          end
          if (has_byte && pos == md5_pkg::LAST_BYTE) begin
            src_next   = md5_pkg::SRC_MSG;
            fin_next   = last;
            state_next = md5_pkg::ST_LOAD;
          end else if (last) begin
            src_next   = md5_pkg::pad_select(has_byte ? pos + 6'd1 : pos);
            fin_next   = 1'b1;
            state_next = md5_pkg::ST_LOAD;
          end
        end
      end
      md5_pkg::ST_LOAD: begin
        ctl.load   = 1'b1;
        ctl.ahead  = '0;
        round_next = '0;
        state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        ctl.step   = 1'b1;
        round_next = round + 6'd1;
        if (round == md5_pkg::LAST_ROUND) begin
          state_next = md5_pkg::ST_ADD;
        end
      end
      md5_pkg::ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_next[i] = chain[i] + work[i];
        end
        case (src)
          md5_pkg::SRC_MSG: begin
            if (fin) begin
              src_next   = md5_pkg::pad_select(pos);
              state_next = md5_pkg::ST_LOAD;
            end else begin
              state_next = md5_pkg::ST_IDLE;
            end
          end
          md5_pkg::SRC_MARK: begin
            src_next   = md5_pkg::SRC_LEN;
            state_next = md5_pkg::ST_LOAD;
          end
          default: state_next = md5_pkg::ST_EMIT;
        endcase
      end
      md5_pkg::ST_EMIT: begin
        if (!digest_valid || !digest_stall) begin
          load_digest       = 1'b1;
          digest_valid_next = 1'b1;
          chain_next        = md5_pkg::CHAIN_INIT;
          count_next        = '0;
          fin_next          = 1'b0;
          src_next          = md5_pkg::SRC_MSG;
          state_next        = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  // The step counter runs the full 64 steps before the chaining add.
  `MD5_ASSERT_NEXT(a_round_end, state == md5_pkg::ST_ROUND && round == md5_pkg::LAST_ROUND, state == md5_pkg::ST_ADD)
  `MD5_ASSERT_NEXT(a_load_start, state == md5_pkg::ST_LOAD, state == md5_pkg::ST_ROUND && round == 6'd0)
  `MD5_ASSERT_NEXT(a_emit_clears, state == md5_pkg::ST_EMIT && (!digest_valid || !digest_stall), digest_valid && count == 61'd0 && state == md5_pkg::ST_IDLE)
  `MD5_ASSERT_NEXT(a_plain_byte, accept && has_byte && !last && pos != md5_pkg::LAST_BYTE, state == md5_pkg::ST_IDLE)
  `MD5_ASSERT_SAME(a_pad_source, state == md5_pkg::ST_EMIT, src == md5_pkg::SRC_MARK_LEN || src == md5_pkg::SRC_LEN)

endmodule
